// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every edge
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// cons must hold in the same cycle as ante
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ppfbw_pkg.sv =====
// ----------------------------------------------------------------------------
// ppfbw_pkg
// Types, widths and codes shared by the frame store writer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ppfbw_pkg;

   localparam int STORE_BYTES_DEF = 262144;

   localparam int DEPTH_W   = 3;
   localparam int LINE_W    = 15;
   localparam int POS_W     = 12;
   localparam int PIX_W     = 32;
   localparam int OFF_W     = POS_W + 2;
   localparam int PROD_W    = POS_W + LINE_W;
   localparam int SUM_W     = PROD_W + 2;
   localparam int CSR_IDX_W = 2;

   localparam logic [DEPTH_W-1:0] DEPTH_1BPP  = 3'd0;
   localparam logic [DEPTH_W-1:0] DEPTH_2BPP  = 3'd1;
   localparam logic [DEPTH_W-1:0] DEPTH_8BPP  = 3'd2;
   localparam logic [DEPTH_W-1:0] DEPTH_16BPP = 3'd3;
   localparam logic [DEPTH_W-1:0] DEPTH_32BPP = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE  = 2'd1;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_READ  = 1'b1;

   typedef struct packed {
      logic clear_step;
      logic load;
      logic calc;
      logic mem_rd;
      logic capture;
      logic rmw_wr;
      logic byte_wr;
      logic push;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic skip;
      logic via_read;
      logic read_mode;
      logic last_byte;
      logic rsp_free;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/packed_pixel_framebuffer_writer_top.sv =====
// ----------------------------------------------------------------------------
// packed_pixel_framebuffer_writer_top
// Packed-pixel frame store with pixel write and byte read access.
// ----------------------------------------------------------------------------
// After reset the store is zeroed one byte per cycle with req_tready low;
// configuration writes are taken throughout. Items are then handled one at
// a time by a state machine over a single byte-wide memory port. An item is
// loaded and its address is calculated and checked; a flagged access or a
// write at an undefined depth then goes straight to the result, a byte read
// or a 1 or 2 bpp write reads the byte and captures it or writes it back
// merged, and a write at 8, 16 or 32 bpp writes its n bytes in turn. The
// next item can be accepted from the cycle in which the result appears, and
// it is taken while a result waits on the response side.
`default_nettype none

module packed_pixel_framebuffer_writer_top #(
   parameter int STORE_BYTES = ppfbw_pkg::STORE_BYTES_DEF
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire  [ppfbw_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire  [ppfbw_pkg::LINE_W-1:0]       csr_data,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire  [55:0]                        req_tdata,  // pos_x, pos_y, pixel_value
   input  wire                                req_tuser,  // mode
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [7:0]                         rsp_tdata,  // read_byte
   output logic                               rsp_tuser   // range_error
);
   import ppfbw_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   ppfbw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ppfbw_dp #(
      .STORE_BYTES (STORE_BYTES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_mode   (req_tuser),
      .req_x      (req_tdata[11:0]),
      .req_y      (req_tdata[23:12]),
      .req_colour (req_tdata[55:24]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_byte   (rsp_tdata),
      .rsp_error  (rsp_tuser),
      .cmd        (cmd),
      .status     (status)
   );

`include "assert_macros.svh"

   `ASSERT_IMPLIES(a_no_accept_in_clear, cmd.clear_step, !req_tready, "item taken during clear")
   `ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready, "second item taken")
   `ASSERT_IMPLIES(a_error_byte_zero, rsp_tvalid && rsp_tuser, rsp_tdata == 8'h00, "flagged nonzero")
   `ASSERT_ALWAYS(a_one_memory_op, !(cmd.mem_rd && (cmd.rmw_wr || cmd.byte_wr)), "port conflict")

endmodule

`default_nettype wire

// ===== rtl/ppfbw_ctrl.sv =====
// ----------------------------------------------------------------------------
// ppfbw_ctrl
// Sequencer for clear, address calculation, byte reads, read-modify-write and byte writes.
// ----------------------------------------------------------------------------
`default_nettype none

module ppfbw_ctrl (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_tvalid,
   output logic                     req_tready,
   input  ppfbw_pkg::status_type    status,
   output ppfbw_pkg::cmd_type       cmd
);
   import ppfbw_pkg::*;

   typedef enum logic [7:0] {
      ST_CLEAR  = 8'b0000_0001,
      ST_IDLE   = 8'b0000_0010,
      ST_CALC   = 8'b0000_0100,
      ST_BRANCH = 8'b0000_1000,
      ST_RD     = 8'b0001_0000,
      ST_MOD    = 8'b0010_0000,
      ST_WR     = 8'b0100_0000,
      ST_DONE   = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = ST_BRANCH;
         end
         ST_BRANCH: begin
            if (status.skip) begin
               state_in = ST_DONE;
            end else if (status.via_read) begin
               state_in = ST_RD;
            end else begin
               state_in = ST_WR;
            end
         end
         ST_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = ST_MOD;
         end
         ST_MOD: begin
            if (status.read_mode) begin
               cmd.capture = 1'b1;
            end else begin
               cmd.rmw_wr = 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_WR: begin
            cmd.byte_wr = 1'b1;
            if (status.last_byte) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               cmd.push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/ppfbw_dp.sv =====
// ----------------------------------------------------------------------------
// ppfbw_dp
// Registers, address arithmetic, frame store memory and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ppfbw_dp #(
   parameter int STORE_BYTES = ppfbw_pkg::STORE_BYTES_DEF
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   csr_valid,
   input  wire  [ppfbw_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [ppfbw_pkg::LINE_W-1:0]          csr_data,
   input  wire                                   req_mode,
   input  wire  [ppfbw_pkg::POS_W-1:0]           req_x,
   input  wire  [ppfbw_pkg::POS_W-1:0]           req_y,
   input  wire  [ppfbw_pkg::PIX_W-1:0]           req_colour,
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   output logic [7:0]                            rsp_byte,
   output logic                                  rsp_error,
   input  ppfbw_pkg::cmd_type                    cmd,
   output ppfbw_pkg::status_type                 status
);
   import ppfbw_pkg::*;

   localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

   logic [7:0]         mem [STORE_BYTES];

   logic [DEPTH_W-1:0] depth_ff;
   logic [LINE_W-1:0]  line_ff;
   logic [AW-1:0]      clr_cnt_ff;
   logic               mode_ff;
   logic [POS_W-1:0]   x_ff;
   logic [PIX_W-1:0]   colour_ff;
   logic [PROD_W-1:0]  product_ff;
   logic [AW-1:0]      addr_ff;
   logic [1:0]         nbm1_ff;
   logic [1:0]         idx_ff;
   logic               err_ff;
   logic               skip_ff;
   logic               via_read_ff;
   logic [7:0]         q_ff;
   logic [7:0]         byte_ff;
   logic               rsp_valid_ff;
   logic [7:0]         rsp_byte_ff;
   logic               rsp_err_ff;

   logic [OFF_W-1:0]   offset;
   logic [1:0]         nbm1;
   logic               undef;
   logic [SUM_W-1:0]   sum;
   logic [SUM_W-1:0]   last;
   logic               err_in;
   logic [2:0]         sh;
   logic [7:0]         mask;
   logic [7:0]         bits;
   logic               we;
   logic [AW-1:0]      wa;
   logic [7:0]         wd;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= DEPTH_8BPP;
         line_ff  <= LINE_W'(1024);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_DEPTH: depth_ff <= csr_data[DEPTH_W-1:0];
            CSR_LINE:  line_ff  <= csr_data;
            default:   ;
         endcase
      end
   end

   // address offset and span for the current access
   always_comb begin
      offset = OFF_W'(x_ff);
      nbm1   = 2'd0;
      undef  = 1'b0;
      if (mode_ff == MODE_WRITE) begin
         unique case (depth_ff)
            DEPTH_1BPP:  offset = OFF_W'(x_ff >> 3);
            DEPTH_2BPP:  offset = OFF_W'(x_ff >> 2);
            DEPTH_8BPP:  offset = OFF_W'(x_ff);
            DEPTH_16BPP: begin
               offset = {1'b0, x_ff, 1'b0};
               nbm1   = 2'd1;
            end
            DEPTH_32BPP: begin
               offset = {x_ff, 2'b00};
               nbm1   = 2'd3;
            end
            default:     undef = 1'b1;
         endcase
      end
      sum    = SUM_W'(product_ff) + SUM_W'(offset);
      last   = sum + SUM_W'(nbm1);
      err_in = !undef && (last >= SUM_W'(STORE_BYTES));
   end

   // packed pixel merge, leftmost pixel in the high bits
   always_comb begin
      if (depth_ff == DEPTH_1BPP) begin
         sh   = x_ff[2:0];
         mask = 8'h80 >> sh;
         bits = {colour_ff[0], 7'b0} >> sh;
      end else begin
         sh   = {x_ff[1:0], 1'b0};
         mask = 8'hC0 >> sh;
         bits = {colour_ff[1:0], 6'b0} >> sh;
      end
   end

   always_comb begin
      we = 1'b0;
      wa = addr_ff;
      wd = 8'h00;
      if (cmd.clear_step) begin
         we = 1'b1;
         wa = clr_cnt_ff;
      end else if (cmd.rmw_wr) begin
         we = 1'b1;
         wd = (q_ff & ~mask) | bits;
      end else if (cmd.byte_wr) begin
         we = 1'b1;
         wa = addr_ff + AW'(idx_ff);
         wd = 8'(colour_ff >> {idx_ff, 3'b000});
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      if (cmd.mem_rd) begin
         q_ff <= mem[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_cnt_ff <= clr_cnt_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff    <= req_mode;
         x_ff       <= req_x;
         colour_ff  <= req_colour;
         product_ff <= PROD_W'(req_y) * PROD_W'(line_ff);
         byte_ff    <= 8'h00;
      end
      if (cmd.calc) begin
         addr_ff     <= sum[AW-1:0];
         nbm1_ff     <= nbm1;
         idx_ff      <= 2'd0;
         err_ff      <= err_in;
         skip_ff     <= undef || err_in;
         via_read_ff <= (mode_ff == MODE_READ) ||
                        (depth_ff == DEPTH_1BPP) || (depth_ff == DEPTH_2BPP);
      end
      if (cmd.byte_wr) begin
         idx_ff <= idx_ff + 2'd1;
      end
      if (cmd.capture) begin
         byte_ff <= q_ff;
      end
   end

   // result register, held until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         rsp_byte_ff <= byte_ff;
         rsp_err_ff  <= err_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_byte   = rsp_byte_ff;
   assign rsp_error  = rsp_err_ff;

   assign status.clear_done = (clr_cnt_ff == AW'(STORE_BYTES - 1));
   assign status.skip       = skip_ff;
   assign status.via_read   = via_read_ff;
   assign status.read_mode  = (mode_ff == MODE_READ);
   assign status.last_byte  = (idx_ff == nbm1_ff);
   assign status.rsp_free   = !rsp_valid_ff || rsp_tready;

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for packed_pixel_framebuffer_writer_top. A shadow copy
// of the frame store and of the depth and line-length registers works out
// the read byte and the range flag of every accepted access. Results are
// checked in order. Directed accesses cover each depth, masked sub-byte
// updates, straddling and out-of-range accesses and undefined depths. Random
// phases follow, each with its own register setting; both sides idle at
// random, except in every fourth phase.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ppfbw_pkg::*;

   localparam int STORE_BYTES = STORE_BYTES_DEF;
   localparam int CYCLE_LIMIT = 900000;
   localparam int DRAIN_CYCLES = 10;
   localparam int HOLD_CYCLES = 250;
   localparam int HOLD_EVERY = 900;
   localparam int PHASE_WORDS = 150;

   localparam logic [DEPTH_W-1:0] DEPTH_UNDEFINED = 3'd7;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_B = 2'd3;

   typedef struct {
      logic             mode;
      logic [POS_W-1:0] px;
      logic [POS_W-1:0] py;
      logic [PIX_W-1:0] colour;
   } pixel_req_type;

   typedef struct {
      logic [7:0] rd_byte;
      logic       range_err;
   } access_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [LINE_W-1:0]    csr_data = '0;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [55:0]          req_tdata = '0;
   logic                 req_tuser = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [7:0]           rsp_tdata;
   logic                 rsp_tuser;

   bit   [7:0]           frame_shadow [STORE_BYTES];
   logic [DEPTH_W-1:0]   cfg_depth = DEPTH_8BPP;
   logic [LINE_W-1:0]    cfg_line = 15'd1024;

   pixel_req_type        pending_pixels[$];
   access_result_type    awaited_results[$];

   bit                   req_fire = 1'b0;
   bit                   rsp_fire = 1'b0;
   bit                   calm = 1'b0;
   int unsigned          req_wait = 0;
   int unsigned          rsp_wait = 0;
   int unsigned          hold_left = 0;
   int unsigned          next_hold = 400;
   int unsigned          accepted_n = 0;
   int unsigned          cycle_n = 0;
   int unsigned          fault_count = 0;

   packed_pixel_framebuffer_writer_top u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int unsigned draw_gap();
      if (calm)
         return 0;
      return $urandom_range(3, 0);
   endfunction

   function automatic access_result_type apply_access(input pixel_req_type it);
      access_result_type r;
      logic [63:0]       base;
      logic [63:0]       addr;
      int unsigned       nbytes;
      logic [7:0]        mask;
      logic [7:0]        bits;
      logic [2:0]        sh;
      r.rd_byte = '0;
      r.range_err = 1'b0;
      base = 64'(it.py) * 64'(cfg_line);
      if (it.mode == MODE_READ) begin
         addr = base + 64'(it.px);
         if (addr >= STORE_BYTES)
            r.range_err = 1'b1;
         else
            r.rd_byte = frame_shadow[addr];
         return r;
      end
      case (cfg_depth)
         DEPTH_1BPP: begin
            addr = base + 64'(it.px >> 3);
            nbytes = 1;
         end
         DEPTH_2BPP: begin
            addr = base + 64'(it.px >> 2);
            nbytes = 1;
         end
         DEPTH_8BPP: begin
            addr = base + 64'(it.px);
            nbytes = 1;
         end
         DEPTH_16BPP: begin
            addr = base + (64'(it.px) << 1);
            nbytes = 2;
         end
         DEPTH_32BPP: begin
            addr = base + (64'(it.px) << 2);
            nbytes = 4;
         end
         default: return r;
      endcase
      if (addr + nbytes > STORE_BYTES) begin
         r.range_err = 1'b1;
         return r;
      end
      if (cfg_depth == DEPTH_1BPP) begin
         sh = it.px[2:0];
         mask = 8'h80 >> sh;
         bits = {it.colour[0], 7'b0} >> sh;
         frame_shadow[addr] = (frame_shadow[addr] & ~mask) | bits;
      end else if (cfg_depth == DEPTH_2BPP) begin
         sh = {it.px[1:0], 1'b0};
         mask = 8'hC0 >> sh;
         bits = {it.colour[1:0], 6'b0} >> sh;
         frame_shadow[addr] = (frame_shadow[addr] & ~mask) | bits;
      end else begin
         for (int k = 0; k < nbytes; k++)
            frame_shadow[addr + k] = it.colour[8*k +: 8];
      end
      return r;
   endfunction

   // keep most accesses in a small window near the origin so reads find
   // earlier writes; the rest land on the last rows or anywhere
   function automatic pixel_req_type random_pixel();
      pixel_req_type it;
      int unsigned   top_row;
      int unsigned   rows;
      int unsigned   pick;
      top_row = (cfg_line == 0) ? 4095 : (STORE_BYTES - 1) / int'(cfg_line);
      if (top_row > 4095)
         top_row = 4095;
      it.mode = ($urandom_range(99, 0) < 35) ? MODE_READ : MODE_WRITE;
      it.colour = $urandom();
      pick = $urandom_range(9, 0);
      if (pick == 0) begin
         it.px = 12'($urandom());
         it.py = 12'($urandom());
      end else if (pick == 1) begin
         it.px = 12'($urandom());
         it.py = (top_row >= 4095) ? 12'd4095 : 12'(top_row + $urandom_range(1, 0));
      end else begin
         rows = (top_row < 3) ? top_row : 3;
         it.py = 12'($urandom_range(rows, 0));
         if (it.mode == MODE_WRITE)
            it.px = 12'($urandom_range(63, 0));
         else if (cfg_depth == DEPTH_1BPP || cfg_depth == DEPTH_2BPP)
            it.px = 12'($urandom_range(15, 0));
         else
            it.px = 12'($urandom_range(63, 0));
      end
      return it;
   endfunction

   task automatic push_pixel(input logic mode, input int x, input int y,
                             input logic [PIX_W-1:0] colour);
      pixel_req_type it;
      it.mode = mode;
      it.px = 12'(x);
      it.py = 12'(y);
      it.colour = colour;
      pending_pixels.push_back(it);
   endtask

   task automatic wait_idle();
      do
         @(negedge clock);
      while (pending_pixels.size() != 0 || req_tvalid || awaited_results.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [LINE_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do
         @(posedge clock);
      while (!csr_ready);
      if (idx == CSR_DEPTH)
         cfg_depth = val[DEPTH_W-1:0];
      else if (idx == CSR_LINE)
         cfg_line = val;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input logic [DEPTH_W-1:0] depth, input logic [LINE_W-1:0] line);
      wait_idle();
      write_csr(CSR_DEPTH, LINE_W'(depth));
      write_csr(CSR_LINE, line);
   endtask

   always @(negedge clock) begin : feed
      pixel_req_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (req_fire)
            req_wait = draw_gap();
         if (req_wait > 0 || pending_pixels.size() == 0) begin
            if (req_wait > 0)
               req_wait--;
            req_tvalid <= 1'b0;
         end else begin
            nxt = pending_pixels.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= nxt.mode;
            req_tdata <= {nxt.colour, nxt.py, nxt.px};
         end
      end
   end

   always @(negedge clock) begin : hold_off
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (accepted_n >= next_hold) begin
         hold_left <= HOLD_CYCLES;
         next_hold <= next_hold + HOLD_EVERY;
      end
   end

   always @(negedge clock) begin : drain
      if (rsp_fire)
         rsp_wait = draw_gap();
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
      end else if (rsp_wait > 0) begin
         rsp_wait--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : observe
      pixel_req_type     seen;
      access_result_type want;
      req_fire = 1'b0;
      rsp_fire = 1'b0;
      if (!reset) begin
         cycle_n++;
         if (cycle_n > CYCLE_LIMIT) begin
            $display("packed_pixel_framebuffer_writer_top verification failed");
            $finish;
         end else begin
            if (req_tvalid && req_tready) begin
               seen.mode = req_tuser;
               seen.px = req_tdata[11:0];
               seen.py = req_tdata[23:12];
               seen.colour = req_tdata[55:24];
               awaited_results.push_back(apply_access(seen));
               accepted_n++;
               req_fire = 1'b1;
            end
            if (rsp_tvalid && rsp_tready) begin
               rsp_fire = 1'b1;
               if (awaited_results.size() == 0) begin
                  $error("unexpected word: read_byte %02h range_error %0b",
                         rsp_tdata, rsp_tuser);
                  fault_count++;
               end else begin
                  want = awaited_results.pop_front();
                  if (rsp_tdata !== want.rd_byte) begin
                     $error("read_byte: expected %02h, got %02h", want.rd_byte, rsp_tdata);
                     fault_count++;
                  end
                  if (rsp_tuser !== want.range_err) begin
                     $error("range_error: expected %0b, got %0b", want.range_err, rsp_tuser);
                     fault_count++;
                  end
               end
            end
         end
      end
   end

   initial begin : stimulus
      logic [DEPTH_W-1:0] depth;
      logic [LINE_W-1:0]  line;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      push_pixel(MODE_WRITE, 0, 0, 32'h12345678);
      push_pixel(MODE_READ, 0, 0, 32'h0);
      push_pixel(MODE_WRITE, 4095, 4095, 32'hFFFFFFFF);
      push_pixel(MODE_READ, 4095, 4095, 32'hFFFFFFFF);
      push_pixel(MODE_READ, 4095, 0, 32'h0);
      push_pixel(MODE_WRITE, 4095, 255, 32'hAB);

      configure(DEPTH_1BPP, 15'd64);
      push_pixel(MODE_WRITE, 0, 0, 32'h1);
      push_pixel(MODE_WRITE, 7, 0, 32'hFFFFFFFF);
      push_pixel(MODE_WRITE, 3, 0, 32'hFFFFFFFE);
      push_pixel(MODE_WRITE, 0, 0, 32'h0);
      push_pixel(MODE_READ, 0, 0, 32'h0);

      configure(DEPTH_2BPP, 15'd64);
      push_pixel(MODE_WRITE, 0, 1, 32'h3);
      push_pixel(MODE_WRITE, 3, 1, 32'hFFFFFFFD);
      push_pixel(MODE_WRITE, 1, 1, 32'h2);
      push_pixel(MODE_READ, 0, 1, 32'h0);

      configure(DEPTH_8BPP, 15'd29127);
      push_pixel(MODE_WRITE, 0, 9, 32'h5A);
      push_pixel(MODE_READ, 0, 9, 32'h0);

      configure(DEPTH_16BPP, 15'd29127);
      push_pixel(MODE_WRITE, 0, 9, 32'hCAFE);
      push_pixel(MODE_WRITE, 1, 0, 32'hBEEF);
      push_pixel(MODE_READ, 3, 0, 32'h0);

      configure(DEPTH_32BPP, 15'd29127);
      push_pixel(MODE_WRITE, 0, 9, 32'hDEADBEEF);
      push_pixel(MODE_WRITE, 1, 0, 32'hDEADBEEF);
      push_pixel(MODE_READ, 7, 0, 32'h0);

      configure(DEPTH_UNDEFINED, 15'd0);
      write_csr(CSR_UNUSED_A, 15'($urandom()));
      write_csr(CSR_UNUSED_B, 15'($urandom()));
      push_pixel(MODE_WRITE, 1, 0, 32'h0);
      push_pixel(MODE_READ, 5, 4095, 32'h0);

      for (int ph = 0; ph < 12; ph++) begin
         depth = (ph < 8) ? DEPTH_W'(ph) : DEPTH_W'($urandom_range(4, 0));
         case ($urandom_range(5, 0))
            0:       line = 15'd0;
            1:       line = 15'd1;
            2:       line = 15'd16384;
            3:       line = 15'd32767;
            4:       line = 15'($urandom_range(256, 8));
            default: line = 15'($urandom_range(16384, 1));
         endcase
         configure(depth, line);
         if (ph == 6)
            write_csr(CSR_UNUSED_A, 15'($urandom()));
         calm = (ph % 4 == 3);
         repeat (PHASE_WORDS) pending_pixels.push_back(random_pixel());
      end

      wait_idle();
      if (fault_count == 0)
         $display("packed_pixel_framebuffer_writer_top verification clean");
      else
         $display("packed_pixel_framebuffer_writer_top verification failed");
      $finish;
   end

endmodule

`default_nettype wire

// ===== packed_pixel_framebuffer_writer_top.f =====
+incdir+rtl
rtl/ppfbw_pkg.sv
rtl/ppfbw_ctrl.sv
rtl/ppfbw_dp.sv
rtl/packed_pixel_framebuffer_writer_top.sv
verif/tb.sv
